[hdl/sd_card_spi_host_sequencer_assert.svh]
// assertion macros for the sd card spi host sequencer
`ifndef SD_CARD_SPI_HOST_SEQUENCER_ASSERT_SVH
`define SD_CARD_SPI_HOST_SEQUENCER_ASSERT_SVH

// assert that a property holds on every rising clock edge outside reset
`define SDS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define SDS_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/sds_pkg.sv]
package sds_pkg;

   localparam int V1_OUTER_TRIES = 10;

   typedef enum logic [2:0] {
      REQ_INIT  = 3'd0,
      REQ_READ  = 3'd1,
      REQ_WRITE = 3'd2,
      REQ_REPLY = 3'd3,
      REQ_WDATA = 3'd4
   } req_kind_type;

   typedef enum logic [1:0] {
      CSR_READY_POLL = 2'd0,
      CSR_TOKEN_POLL = 2'd1,
      CSR_V2_TRIES   = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_NO_CARD = 3'd1,
      ST_REJECT  = 3'd2,
      ST_TIMEOUT = 3'd3,
      ST_WR_BAD  = 3'd4
   } status_type;

   typedef enum logic [5:0] {
      P_IDLE, P_INIT_CLK, P_CMD_RDY0, P_CMD_RDY, P_CMD_FRAME, P_CMD_R1,
      P_OCR8, P_OCR58, P_R_TOKEN, P_R_DATA, P_R_CRC,
      P_W_RDY0, P_W_RDY, P_W_TOKEN, P_W_NEED, P_W_DATA, P_W_CRC, P_W_RESP,
      R_CMD0, R_CMD8, R_V1CHK55, R_V1CHK41, R_V1SD55, R_V1SD41, R_V1MMC,
      R_16SD1, R_16MMC, R_V255, R_V241, R_CMD58, R_CMD17, R_CMD24
   } phase_type;

   typedef enum logic [1:0] {
      PEND_NONE  = 2'd0,
      PEND_INIT  = 2'd1,
      PEND_READ  = 2'd2,
      PEND_WRITE = 2'd3
   } pend_type;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [31:0] sector;
      logic [7:0]  card_byte;
      logic [7:0]  write_byte;
   } req_type_type;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       card_selected;
      logic       fast_clock;
      logic       data_valid;
      logic [7:0] data_byte;
      logic       data_last;
      logic       need_write_data;
      logic       done_res;
      logic [2:0] status;
      logic [2:0] card_kind;
   } rsp_type;

   typedef struct packed {
      logic   [1:0] count;
      rsp_type [2:0] items;
   } rsp_group_type;

   typedef struct packed {
      logic [15:0] ready_poll_limit;
      logic [15:0] token_poll_limit;
      logic [15:0] v2_init_tries;
   } csr_type;

endpackage

[hdl/sds_core.sv]
module sds_core #(
   parameter int BLOCK_BYTES    = 512,
   parameter int REPLY_POLLS    = 10,
   parameter int V1_INNER_TRIES = 100
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  sds_pkg::req_type_type req,
   input  sds_pkg::csr_type      csr,
   output sds_pkg::rsp_group_type grp
);
   import sds_pkg::*;

   localparam int FW = $clog2(BLOCK_BYTES + 1) + 1;

   phase_type   phase_ff, phase_in, ret_ff, ret_in;
   pend_type    pend_ff, pend_in;
   logic [2:0]  kind_ff, kind_in;
   logic [5:0]  cidx_ff, cidx_in;
   logic [31:0] carg_ff, carg_in;
   logic [FW-1:0] fcnt_ff, fcnt_in;
   logic [15:0] poll_ff, poll_in;
   logic [3:0]  outer_ff, outer_in;
   logic [6:0]  inner_ff, inner_in;
   logic [31:0] ocr_ff, ocr_in;
   logic [15:0] v2t_ff, v2t_in;
   logic [31:0] sect_ff, sect_in;

   logic [15:0] rp_lim, tp_lim, v2_lim;
   logic [7:0]  b;
   logic        do_disp;
   logic [7:0]  dr;
   logic        done;
   logic [2:0]  dst;
   logic        dv, dl;
   logic [7:0]  db;
   logic        emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_IDLE;
         ret_ff   <= P_IDLE;
         pend_ff  <= PEND_NONE;
         kind_ff  <= '0;
         cidx_ff  <= '0;
         carg_ff  <= '0;
         fcnt_ff  <= '0;
         poll_ff  <= '0;
         outer_ff <= '0;
         inner_ff <= '0;
         ocr_ff   <= '0;
         v2t_ff   <= '0;
         sect_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         ret_ff   <= ret_in;
         pend_ff  <= pend_in;
         kind_ff  <= kind_in;
         cidx_ff  <= cidx_in;
         carg_ff  <= carg_in;
         fcnt_ff  <= fcnt_in;
         poll_ff  <= poll_in;
         outer_ff <= outer_in;
         inner_ff <= inner_in;
         ocr_ff   <= ocr_in;
         v2t_ff   <= v2t_in;
         sect_ff  <= sect_in;
      end
   end

   always_comb begin
      logic [31:0] addr;
      logic [7:0]  txb;
      logic        sel;
      rsp_type     r;
      phase_in = phase_ff;
      ret_in   = ret_ff;
      pend_in  = pend_ff;
      kind_in  = kind_ff;
      cidx_in  = cidx_ff;
      carg_in  = carg_ff;
      fcnt_in  = fcnt_ff;
      poll_in  = poll_ff;
      outer_in = outer_ff;
      inner_in = inner_ff;
      ocr_in   = ocr_ff;
      v2t_in   = v2t_ff;
      sect_in  = sect_ff;
      rp_lim   = (csr.ready_poll_limit == '0) ? 16'd1 : csr.ready_poll_limit;
      tp_lim   = (csr.token_poll_limit == '0) ? 16'd1 : csr.token_poll_limit;
      v2_lim   = (csr.v2_init_tries == '0) ? 16'd1 : csr.v2_init_tries;
      b        = req.card_byte;
      do_disp  = 1'b0;
      dr       = 8'hFF;
      done     = 1'b0;
      dst      = ST_OK;
      dv       = 1'b0;
      dl       = 1'b0;
      db       = '0;
      emit     = 1'b0;
      grp      = '0;
      addr     = '0;
      txb      = 8'hFF;
      sel      = 1'b0;
      r        = '0;

      case (req.req_type)
         REQ_INIT, REQ_READ, REQ_WRITE: begin
            if (phase_ff == P_IDLE) begin
               emit    = 1'b1;
               sect_in = req.sector;
               addr    = (kind_ff == 3'd4) ? req.sector : {req.sector[22:0], 9'd0};
               if (req.req_type == REQ_INIT) begin
                  pend_in = PEND_INIT; kind_in = '0; fcnt_in = '0;
                  phase_in = P_INIT_CLK;
               end else if (req.req_type == REQ_READ) begin
                  pend_in = PEND_READ;
                  if (kind_ff == '0) begin
                     fcnt_in = '0; phase_in = P_INIT_CLK;
                  end else begin
                     cidx_in = 6'd17; carg_in = addr; ret_in = R_CMD17;
                     phase_in = P_CMD_RDY0;
                  end
               end else if (kind_ff == '0) begin
                  done = 1'b1; dst = ST_NO_CARD;
               end else begin
                  pend_in = PEND_WRITE;
                  cidx_in = 6'd24; carg_in = addr; ret_in = R_CMD24;
                  phase_in = P_CMD_RDY0;
               end
            end
         end
         REQ_REPLY: begin
            if (phase_ff != P_IDLE && phase_ff != P_W_NEED) begin
               emit = 1'b1;
               case (phase_ff)
                  P_INIT_CLK: begin
                     fcnt_in = fcnt_ff + 1'b1;
                     if (fcnt_in >= FW'(10)) begin
                        cidx_in = 6'd0; carg_in = '0; ret_in = R_CMD0;
                        phase_in = P_CMD_RDY0;
                     end
                  end
                  P_CMD_RDY0: begin
                     poll_in = '0; phase_in = P_CMD_RDY;
                  end
                  P_CMD_RDY: begin
                     if (b == 8'hFF) begin
                        fcnt_in = '0; phase_in = P_CMD_FRAME;
                     end else begin
                        poll_in = poll_ff + 1'b1;
                        if (poll_in >= rp_lim) begin
                           do_disp = 1'b1; dr = 8'hFF;
                        end
                     end
                  end
                  P_CMD_FRAME: begin
                     fcnt_in = fcnt_ff + 1'b1;
                     if (fcnt_in >= FW'(6)) begin
                        poll_in = '0; phase_in = P_CMD_R1;
                     end
                  end
                  P_CMD_R1: begin
                     poll_in = poll_ff + 1'b1;
                     if (!b[7] || poll_in >= 16'(REPLY_POLLS)) begin
                        do_disp = 1'b1; dr = b;
                     end
                  end
                  P_OCR8, P_OCR58: begin
                     ocr_in  = {ocr_ff[23:0], b};
                     fcnt_in = fcnt_ff + 1'b1;
                     if (fcnt_in >= FW'(4)) begin
                        if (phase_ff == P_OCR58) begin
                           kind_in = ocr_in[30] ? 3'd4 : 3'd3;
                           if (pend_ff == PEND_READ) begin
                              cidx_in = 6'd17;
                              carg_in = kind_in == 3'd4 ? sect_ff : {sect_ff[22:0], 9'd0};
                              ret_in = R_CMD17; phase_in = P_CMD_RDY0;
                           end else begin
                              done = 1'b1;
                           end
                        end else if (ocr_in[15:0] == 16'h01AA) begin
                           v2t_in = '0; cidx_in = 6'd55; carg_in = '0;
                           ret_in = R_V255; phase_in = P_CMD_RDY0;
                        end else begin
                           kind_in = '0; done = 1'b1; dst = ST_NO_CARD;
                        end
                     end
                  end
                  P_R_TOKEN: begin
                     if (b == 8'hFE) begin
                        fcnt_in = '0; phase_in = P_R_DATA;
                     end else begin
                        poll_in = poll_ff + 1'b1;
                        if (poll_in >= tp_lim) begin
                           done = 1'b1; dst = ST_TIMEOUT;
                        end
                     end
                  end
                  P_R_DATA: begin
                     dv = 1'b1; db = b;
                     dl = fcnt_ff >= FW'(BLOCK_BYTES - 1);
                     fcnt_in = fcnt_ff + 1'b1;
                     if (dl) begin
                        fcnt_in = '0; phase_in = P_R_CRC;
                     end
                  end
                  P_R_CRC: begin
                     fcnt_in = fcnt_ff + 1'b1;
                     if (fcnt_in >= FW'(2)) done = 1'b1;
                  end
                  P_W_RDY0: begin
                     poll_in = '0; phase_in = P_W_RDY;
                  end
                  P_W_RDY: begin
                     if (b == 8'hFF) phase_in = P_W_TOKEN;
                     else begin
                        poll_in = poll_ff + 1'b1;
                        if (poll_in >= rp_lim) begin
                           done = 1'b1; dst = ST_TIMEOUT;
                        end
                     end
                  end
                  P_W_TOKEN: begin
                     fcnt_in = '0; phase_in = P_W_NEED;
                  end
                  P_W_DATA: begin
                     fcnt_in = fcnt_ff + 1'b1;
                     if (fcnt_in >= FW'(BLOCK_BYTES)) begin
                        fcnt_in = '0; phase_in = P_W_CRC;
                     end else begin
                        phase_in = P_W_NEED;
                     end
                  end
                  P_W_CRC: begin
                     fcnt_in = fcnt_ff + 1'b1;
                     if (fcnt_in >= FW'(2)) phase_in = P_W_RESP;
                  end
                  P_W_RESP: begin
                     done = 1'b1;
                     dst = (b[4:0] != 5'h05) ? ST_WR_BAD : ST_OK;
                  end
                  default: ;
               endcase

               if (do_disp) begin
                  case (ret_ff)
                     R_CMD0: begin
                        if (dr != 8'd1) begin
                           kind_in = '0; done = 1'b1; dst = ST_NO_CARD;
                        end else begin
                           cidx_in = 6'd8; carg_in = 32'h1AA; ret_in = R_CMD8;
                           phase_in = P_CMD_RDY0;
                        end
                     end
                     R_CMD8: begin
                        if (dr == 8'd1) begin
                           fcnt_in = '0; ocr_in = '0; phase_in = P_OCR8;
                        end else begin
                           outer_in = '0; cidx_in = 6'd55; carg_in = '0;
                           ret_in = R_V1CHK55; phase_in = P_CMD_RDY0;
                        end
                     end
                     R_V1CHK55, R_V1CHK41: begin
                        if (ret_ff == R_V1CHK55 && dr[7:1] == '0) begin
                           cidx_in = 6'd41; carg_in = '0; ret_in = R_V1CHK41;
                        end else begin
                           inner_in = '0; carg_in = '0;
                           if (dr <= 8'd1) begin
                              cidx_in = 6'd55; ret_in = R_V1SD55;
                           end else begin
                              cidx_in = 6'd1; ret_in = R_V1MMC;
                           end
                        end
                        phase_in = P_CMD_RDY0;
                     end
                     R_V1SD55, R_V1SD41, R_V1MMC: begin
                        carg_in = '0;
                        if (ret_ff == R_V1SD55 && dr[7:1] == '0) begin
                           cidx_in = 6'd41; ret_in = R_V1SD41; phase_in = P_CMD_RDY0;
                        end else if (ret_ff != R_V1SD55 && dr == '0) begin
                           cidx_in = 6'd16; carg_in = 32'(BLOCK_BYTES);
                           ret_in = (ret_ff == R_V1MMC) ? R_16MMC : R_16SD1;
                           phase_in = P_CMD_RDY0;
                        end else begin
                           inner_in = inner_ff + 1'b1;
                           if (inner_in < 7'(V1_INNER_TRIES)) begin
                              if (ret_ff == R_V1MMC) begin
                                 cidx_in = 6'd1; ret_in = R_V1MMC;
                              end else begin
                                 cidx_in = 6'd55; ret_in = R_V1SD55;
                              end
                              phase_in = P_CMD_RDY0;
                           end else begin
                              outer_in = outer_ff + 1'b1;
                              if (outer_in < 4'(V1_OUTER_TRIES)) begin
                                 cidx_in = 6'd55; ret_in = R_V1CHK55;
                                 phase_in = P_CMD_RDY0;
                              end else begin
                                 kind_in = '0; done = 1'b1; dst = ST_NO_CARD;
                              end
                           end
                        end
                     end
                     R_16SD1, R_16MMC: begin
                        if (dr != '0) begin
                           kind_in = '0; done = 1'b1; dst = ST_NO_CARD;
                        end else begin
                           kind_in = (ret_ff == R_16MMC) ? 3'd1 : 3'd2;
                           if (pend_ff == PEND_READ) begin
                              cidx_in = 6'd17; carg_in = {sect_ff[22:0], 9'd0};
                              ret_in = R_CMD17; phase_in = P_CMD_RDY0;
                           end else begin
                              done = 1'b1;
                           end
                        end
                     end
                     R_V255, R_V241: begin
                        if (ret_ff == R_V255 && dr[7:1] == '0) begin
                           cidx_in = 6'd41; carg_in = 32'h4000_0000;
                           ret_in = R_V241; phase_in = P_CMD_RDY0;
                        end else if (dr == '0) begin
                           cidx_in = 6'd58; carg_in = '0; ret_in = R_CMD58;
                           phase_in = P_CMD_RDY0;
                        end else begin
                           v2t_in = v2t_ff + 1'b1;
                           if (v2t_in >= v2_lim) begin
                              kind_in = '0; done = 1'b1; dst = ST_NO_CARD;
                           end else begin
                              cidx_in = 6'd55; carg_in = '0; ret_in = R_V255;
                              phase_in = P_CMD_RDY0;
                           end
                        end
                     end
                     R_CMD58: begin
                        if (dr != '0) begin
                           kind_in = '0; done = 1'b1; dst = ST_NO_CARD;
                        end else begin
                           fcnt_in = '0; ocr_in = '0; phase_in = P_OCR58;
                        end
                     end
                     R_CMD17: begin
                        if (dr != '0) begin
                           done = 1'b1; dst = ST_REJECT;
                        end else begin
                           poll_in = '0; phase_in = P_R_TOKEN;
                        end
                     end
                     R_CMD24: begin
                        if (dr != '0) begin
                           done = 1'b1; dst = ST_REJECT;
                        end else begin
                           phase_in = P_W_RDY0;
                        end
                     end
                     default: begin
                        done = 1'b1; dst = ST_REJECT;
                     end
                  endcase
               end
            end
         end
         REQ_WDATA: begin
            if (phase_ff == P_W_NEED) begin
               emit = 1'b1; phase_in = P_W_DATA;
            end
         end
         default: ;
      endcase

      if (done) begin
         phase_in = P_IDLE; pend_in = PEND_NONE;
      end

      // the byte to exchange uses the state after the step
      case (phase_in)
         P_W_TOKEN: txb = 8'hFE;
         P_W_DATA:  txb = req.write_byte;
         P_CMD_FRAME: begin
            if (fcnt_in == '0) txb = {2'b01, cidx_in};
            else if (fcnt_in == FW'(1)) txb = carg_in[31:24];
            else if (fcnt_in == FW'(2)) txb = carg_in[23:16];
            else if (fcnt_in == FW'(3)) txb = carg_in[15:8];
            else if (fcnt_in == FW'(4)) txb = carg_in[7:0];
            else if (cidx_in == 6'd0) txb = 8'h95;
            else if (cidx_in == 6'd8) txb = 8'h87;
            else txb = 8'h01;
         end
         default: txb = 8'hFF;
      endcase

      sel = (kind_in != '0) ||
            (phase_in != P_IDLE && phase_in != P_INIT_CLK &&
             (pend_in == PEND_INIT || pend_in == PEND_READ));

      r = '0;
      r.card_selected = sel;
      r.fast_clock    = kind_in != '0;
      r.card_kind     = kind_in;

      if (emit) begin
         if (dv) begin
            grp.items[grp.count] = r;
            grp.items[grp.count].data_valid = 1'b1;
            grp.items[grp.count].data_byte  = db;
            grp.items[grp.count].data_last  = dl;
            grp.count = grp.count + 1'b1;
         end
         if (done) begin
            grp.items[grp.count] = r;
            grp.items[grp.count].done_res = 1'b1;
            grp.items[grp.count].status   = dst;
            grp.count = grp.count + 1'b1;
         end
         if (phase_in == P_W_NEED) begin
            grp.items[grp.count] = r;
            grp.items[grp.count].need_write_data = 1'b1;
            grp.count = grp.count + 1'b1;
         end else if (phase_in != P_IDLE) begin
            grp.items[grp.count] = r;
            grp.items[grp.count].tx_valid = 1'b1;
            grp.items[grp.count].tx_byte  = txb;
            grp.count = grp.count + 1'b1;
         end
      end
   end

endmodule

[hdl/sds_out_queue.sv]
module sds_out_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  sds_pkg::rsp_group_type grp,
   output logic                   empty,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output sds_pkg::rsp_type       rsp_data
);
   import sds_pkg::*;

   rsp_type [2:0] items_ff, items_in;
   logic [1:0] cnt_ff, cnt_in;
   logic [1:0] head_ff, head_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         head_ff <= '0;
      end else begin
         cnt_ff  <= cnt_in;
         head_ff <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      items_ff <= items_in;
   end

   always_comb begin
      items_in = items_ff;
      cnt_in   = cnt_ff;
      head_in  = head_ff;
      if (rsp_valid && rsp_ready) begin
         cnt_in  = cnt_ff - 1'b1;
         head_in = head_ff + 1'b1;
      end
      if (load) begin
         items_in = grp.items;
         cnt_in   = grp.count;
         head_in  = '0;
      end
   end

   assign empty     = (cnt_ff == '0) || (cnt_ff == 2'd1 && rsp_ready);
   assign rsp_valid = cnt_ff != '0;
   assign rsp_data  = (head_ff == 2'd0) ? items_ff[0] :
                      (head_ff == 2'd1) ? items_ff[1] : items_ff[2];

endmodule

[hdl/sd_card_spi_host_sequencer.sv]
// sd card spi-mode host sequencer
// req channel: one transaction per request (init, read, write) or per
// card reply byte / write data byte. rsp channel: zero to two result
// transactions per request, each a byte to exchange, a read data byte,
// a write data request or a done status.
// csr channel: register writes, index 0 ready poll limit, 1 token poll
// limit, 2 v2 init tries; accepted in any cycle.
// output: results of a request are registered and appear in the cycle after acceptance.
// throughput: one request per cycle while rsp_ready is high and each request
// yields at most one result; with more results req_ready stays low until the
// last is being taken, as the output queue drains one result a cycle.
// reset: synchronous, returns to idle with no card known and registers at
// their reset values (4096, 4096, 1000).
// stall: when rsp_ready is low, queued results hold and req_ready drops
// once the queue cannot drain this cycle.
module sd_card_spi_host_sequencer #(
   parameter int BLOCK_BYTES    = 512,
   parameter int REPLY_POLLS    = 10,
   parameter int V1_INNER_TRIES = 100
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  sds_pkg::req_type_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output sds_pkg::rsp_type      rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [15:0]           csr_wdata
);
   import sds_pkg::*;

   csr_type       csr_ff;
   rsp_group_type grp;
   logic          empty, step;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.ready_poll_limit <= 16'd4096;
         csr_ff.token_poll_limit <= 16'd4096;
         csr_ff.v2_init_tries    <= 16'd1000;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_READY_POLL: csr_ff.ready_poll_limit <= csr_wdata;
            CSR_TOKEN_POLL: csr_ff.token_poll_limit <= csr_wdata;
            CSR_V2_TRIES:   csr_ff.v2_init_tries    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign req_ready = empty;
   assign step      = req_valid && req_ready;

   sds_core #(
      .BLOCK_BYTES(BLOCK_BYTES),
      .REPLY_POLLS(REPLY_POLLS),
      .V1_INNER_TRIES(V1_INNER_TRIES)
   ) u_core (
      .clock(clock),
      .reset(reset),
      .step(step),
      .req(req_data),
      .csr(csr_ff),
      .grp(grp)
   );

   sds_out_queue u_queue (
      .clock(clock),
      .reset(reset),
      .load(step),
      .grp(grp),
      .empty(empty),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

endmodule

[hdl/sds_checker.sv]
module sd_card_spi_host_sequencer_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input sds_pkg::rsp_type rsp_data
);
   import sds_pkg::*;
`include "sd_card_spi_host_sequencer_assert.svh"

   `SDS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "rsp dropped while stalled")
   `SDS_ASSERT(a_fast_kind, clock, reset, rsp_valid |-> (rsp_data.fast_clock == (rsp_data.card_kind != 3'd0)), "fast clock and card kind disagree")
   `SDS_ASSERT(a_one_kind, clock, reset, rsp_valid |-> $countones({rsp_data.tx_valid, rsp_data.data_valid, rsp_data.need_write_data, rsp_data.done_res}) == 1, "result carries not exactly one kind")
   `SDS_ASSERT(a_ready_busy, clock, reset, !req_ready |-> rsp_valid, "req blocked with no result waiting")
   `SDS_ASSERT_NR(a_reset_idle, clock, reset |=> !rsp_valid, "result after reset")

endmodule

bind sd_card_spi_host_sequencer sd_card_spi_host_sequencer_checker u_checker (
   .clock(clock),
   .reset(reset),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data(rsp_data)
);
